// ----- hdl/ega_pkg.sv -----
// package for the embedding gradient accumulator: sizes, opcodes, float add
`default_nettype none
package ega_pkg;
   localparam int unsigned MAX_ROWS_DEF = 256;
   localparam int unsigned MAX_COLS_DEF = 64;
   localparam int unsigned ROW_W = 8;
   localparam int unsigned COL_W = 6;
   localparam int unsigned ROWS_CFG_W = 9;
   localparam int unsigned COLS_CFG_W = 7;
   localparam int unsigned CSR_W = 9;
   localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
   localparam logic [31:0] FP_ZERO = 32'h0000_0000;

   localparam logic [1:0] OP_ACC = 2'd0;
   localparam logic [1:0] OP_READ = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic CSR_ROWS = 1'b0;
   localparam logic CSR_COLS = 1'b1;

   // unpacked operand after alignment: the first half of the adder
   typedef struct packed {
      logic        special;
      logic [31:0] special_val;
      logic        sign_a;
      logic        sign_b;
      logic [7:0]  exp;
      logic [26:0] man_a;  // hidden, 23 fraction, guard, round, sticky
      logic [26:0] man_b;
   } fadd_align_type;

   // exponent compare, special cases and alignment shift
   function automatic fadd_align_type fadd_align(input logic [31:0] a, input logic [31:0] b);
      fadd_align_type r;
      logic [7:0] ea, eb, d;
      logic [23:0] ma, mb;
      logic [26:0] xa, xb, sh;
      logic swap, st;
      logic ana, anb, aia, aib;
      r = '0;
      ea = a[30:23];
      eb = b[30:23];
      ana = (ea == 8'hFF) && (a[22:0] != 0);
      anb = (eb == 8'hFF) && (b[22:0] != 0);
      aia = (ea == 8'hFF) && (a[22:0] == 0);
      aib = (eb == 8'hFF) && (b[22:0] == 0);
      if (ana || anb || (aia && aib && (a[31] != b[31]))) begin
         r.special = 1'b1;
         r.special_val = CANON_NAN;
      end else if (aia) begin
         r.special = 1'b1;
         r.special_val = a;
      end else if (aib) begin
         r.special = 1'b1;
         r.special_val = b;
      end
      ma = {ea != 0, a[22:0]};
      mb = {eb != 0, b[22:0]};
      if (ea == 0) ea = 8'd1;
      if (eb == 0) eb = 8'd1;
      swap = {ea, ma} < {eb, mb};
      if (swap) begin
         xa = {mb, 3'b000};
         xb = {ma, 3'b000};
         r.exp = eb;
         d = eb - ea;
         r.sign_a = b[31];
         r.sign_b = a[31];
      end else begin
         xa = {ma, 3'b000};
         xb = {mb, 3'b000};
         r.exp = ea;
         d = ea - eb;
         r.sign_a = a[31];
         r.sign_b = b[31];
      end
      if (d > 8'd26) begin
         st = (xb != 0);
         sh = {26'd0, st};
      end else begin
         sh = xb >> d;
         st = ((sh << d) != xb);
         sh[0] = sh[0] | st;
      end
      r.man_a = xa;
      r.man_b = sh;
      return r;
   endfunction

   // add, normalise and round to nearest even
   function automatic logic [31:0] fadd_finish(input fadd_align_type p);
      logic [27:0] s;
      logic [26:0] m;
      logic [9:0] e;
      logic [4:0] lz;
      logic found;
      logic [24:0] rm;
      logic rnd;
      logic [31:0] res;
      if (p.sign_a == p.sign_b) s = {1'b0, p.man_a} + {1'b0, p.man_b};
      else s = {1'b0, p.man_a} - {1'b0, p.man_b};
      e = {2'b00, p.exp};
      if (s == 0) begin
         res = {p.sign_a & p.sign_b, 31'd0};
      end else begin
         if (s[27]) begin
            m = s[27:1];
            m[0] = m[0] | s[0];
            e = e + 10'd1;
         end else begin
            lz = 5'd0;
            found = 1'b0;
            for (int i = 26; i >= 0; i--) begin
               if (!found && s[i]) begin
                  found = 1'b1;
                  lz = 5'(26 - i);
               end
            end
            // keep the exponent no lower than one: subnormal result
            if ({5'd0, lz} >= e) lz = 5'(e - 10'd1);
            m = s[26:0] << lz;
            e = e - {5'd0, lz};
         end
         rnd = m[2] & (m[1] | m[0] | m[3]);
         rm = {1'b0, m[26:3]} + {24'd0, rnd};
         if (rm[24]) begin
            rm = rm >> 1;
            e = e + 10'd1;
         end
         if (e >= 10'd255) res = {p.sign_a, 8'hFF, 23'd0};
         else if (!rm[23]) res = {p.sign_a, 8'd0, rm[22:0]};
         else res = {p.sign_a, e[7:0], rm[22:0]};
      end
      if (p.special) res = p.special_val;
      return res;
   endfunction
endpackage
`default_nettype wire

// ----- hdl/ega_ram.sv -----
// generic single-port-write, registered-read ram
`default_nettype none
module ega_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- hdl/embedding_gradient_accumulator_top.sv -----
// top level of the embedding gradient accumulator
`default_nettype none
// scatter-add table of MAX_ROWS x MAX_COLS ieee single entries in one ram.
// req_ channel: an item transfers when start is high and busy is low.
//   opcode accumulate adds req_grad_value into (row, col) and returns the sum,
//   read returns the entry, clear zeroes the table and returns nothing,
//   opcode three is dropped. out-of-range row/col: rsp_range_error 1, value 0.
// rsp_ channel: rsp_valid strobes one cycle per result; no back-pressure.
// csr_ port: csr_wr_en, csr_index (0 rows_in_use, 1 cols_in_use), csr_wdata.
// timing: a read passes the address register, the ram read and the result
//   register before its result transfer; an accumulate passes the address
//   register, the ram read, align, then add and write back. busy covers them,
//   so a new item is taken only once the last is done, set by the ram
//   read-modify-write loop with no overlap between items.
// out-of-range items answer in the cycle after the transfer and leave busy low,
//   so they can follow back to back.
// clear sweeps the ram one entry a cycle and stays busy until every entry is zero.
// reset: a sweep over every entry clears the ram after reset; busy stays
//   high throughout, csr writes are taken as ever.
module embedding_gradient_accumulator_top #(
   parameter int unsigned MAX_ROWS = ega_pkg::MAX_ROWS_DEF,
   parameter int unsigned MAX_COLS = ega_pkg::MAX_COLS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [1:0]                      req_opcode,
   input  wire logic [ega_pkg::ROW_W-1:0]       req_row_index,
   input  wire logic [ega_pkg::COL_W-1:0]       req_col_index,
   input  wire logic [31:0]                     req_grad_value,
   output logic                                 rsp_valid,
   output logic [31:0]                          rsp_entry_value,
   output logic                                 rsp_range_error,
   input  wire logic                            csr_wr_en,
   input  wire logic                            csr_index,
   input  wire logic [ega_pkg::CSR_W-1:0]       csr_wdata
);
   localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int unsigned CAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   typedef enum logic [2:0] {S_SWEEP, S_IDLE, S_RD, S_ALIGN, S_ADD} state_type;

   state_type state_ff;
   logic [AW-1:0] sweep_ff;
   logic [8:0] rows_ff;
   logic [6:0] cols_ff;
   logic is_acc_ff;
   logic [AW-1:0] addr_ff;
   logic [31:0] grad_ff;
   ega_pkg::fadd_align_type align_ff;
   logic rsp_valid_ff, rsp_err_ff;
   logic [31:0] rsp_val_ff;

   logic [31:0] rd_data, sum;
   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr, req_addr;
   logic [31:0] wr_data;
   logic in_range;
   logic [31:0] row_lim, col_lim;
   logic accept;

   assign accept = start && !busy;
   assign busy = (state_ff != S_IDLE);

   // effective limits: register clipped to the build-time maximum
   assign row_lim = (32'(rows_ff) < MAX_ROWS) ? 32'(rows_ff) : MAX_ROWS;
   assign col_lim = (32'(cols_ff) < MAX_COLS) ? 32'(cols_ff) : MAX_COLS;
   assign in_range = (32'(req_row_index) < row_lim) && (32'(req_col_index) < col_lim);
   assign req_addr = AW'(32'(RAW'(req_row_index)) * MAX_COLS + 32'(CAW'(req_col_index)));

   assign sum = ega_pkg::fadd_finish(align_ff);
   assign rd_addr = addr_ff;

   always_comb begin
      wr_en = 1'b0;
      wr_addr = addr_ff;
      wr_data = sum;
      if (state_ff == S_SWEEP) begin
         wr_en = 1'b1;
         wr_addr = sweep_ff;
         wr_data = ega_pkg::FP_ZERO;
      end else if (state_ff == S_ADD) begin
         wr_en = 1'b1;
      end
   end

   ega_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
         sweep_ff <= '0;
         rows_ff <= 9'd256;
         cols_ff <= 7'd64;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_wr_en) begin
            case (csr_index)
               ega_pkg::CSR_ROWS: rows_ff <= csr_wdata;
               ega_pkg::CSR_COLS: cols_ff <= csr_wdata[6:0];
               default: ;
            endcase
         end
         case (state_ff)
            S_SWEEP: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_ff == AW'(DEPTH - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (accept) begin
                  addr_ff <= req_addr;
                  grad_ff <= req_grad_value;
                  is_acc_ff <= (req_opcode == ega_pkg::OP_ACC);
                  case (req_opcode)
                     ega_pkg::OP_CLEAR: begin
                        sweep_ff <= '0;
                        state_ff <= S_SWEEP;
                     end
                     ega_pkg::OP_ACC, ega_pkg::OP_READ: begin
                        if (in_range) state_ff <= S_RD;
                        else begin
                           rsp_valid_ff <= 1'b1;
                           rsp_err_ff <= 1'b1;
                           rsp_val_ff <= '0;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_RD: state_ff <= S_ALIGN;
            S_ALIGN: begin
               if (is_acc_ff) begin
                  align_ff <= ega_pkg::fadd_align(rd_data, grad_ff);
                  state_ff <= S_ADD;
               end else begin
                  rsp_valid_ff <= 1'b1;
                  rsp_err_ff <= 1'b0;
                  rsp_val_ff <= rd_data;
                  state_ff <= S_IDLE;
               end
            end
            S_ADD: begin
               rsp_valid_ff <= 1'b1;
               rsp_err_ff <= 1'b0;
               rsp_val_ff <= sum;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_entry_value = rsp_val_ff;
   assign rsp_range_error = rsp_err_ff;

   // a result never appears while the table is being swept
   a_no_rsp_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP) |-> !rsp_valid)
      else $error("result during sweep");
   // an error result always carries a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_range_error) |-> (rsp_entry_value == 32'd0))
      else $error("range error with non-zero value");
   // an accumulate write back is followed by its result
   a_add_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADD) |=> rsp_valid)
      else $error("missing accumulate result");
endmodule
`default_nettype wire
